@@ src/sus_pkg.sv @@
// ----------------------------------------------------------------------------
// sus_pkg
// Shared types and constants for the sorted unique address set.
// ----------------------------------------------------------------------------
package sus_pkg;

  localparam int DEFAULT_CAPACITY = 16;
  localparam int ADDR_W           = 64;

  typedef logic [ADDR_W-1:0] addr_t;

  // request command
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_TAKE   = 1'b1
  } cmd_t;

  // result status
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // operation broadcast to every cell
  typedef enum logic [1:0] {
    OP_HOLD      = 2'd0,  // no change
    OP_INSERT    = 2'd1,  // open a slot and write the address
    OP_TAKE_MIN  = 2'd2,  // drop slot 0
    OP_TAKE_HIT  = 2'd3   // drop the slot that matches the address
  } op_t;

  // per-cell compare flags
  typedef struct packed {
    logic lt;  // holds a valid entry below the address
    logic eq;  // holds a valid entry equal to the address
  } cell_flags_t;

endpackage

@@ src/sus_if.sv @@
// ----------------------------------------------------------------------------
// sus_req_if / sus_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface sus_req_if;
  import sus_pkg::*;

  logic  valid;
  logic  ready;
  cmd_t  cmd;
  addr_t address;
  logic  use_preferred;

  modport source (output valid, output cmd, output address, output use_preferred,
                  input ready);
  modport sink   (input valid, input cmd, input address, input use_preferred,
                  output ready);
endinterface

interface sus_rsp_if;
  import sus_pkg::*;

  logic    valid;
  logic    ready;
  addr_t   taken_address;
  status_t status;
  logic    nonempty;

  modport source (output valid, output taken_address, output status, output nonempty,
                  input ready);
  modport sink   (input valid, input taken_address, input status, input nonempty,
                  output ready);
endinterface

@@ src/sorted_unique_address_set.sv @@
// ----------------------------------------------------------------------------
// sorted_unique_address_set
// Sorted set of unique 64-bit addresses with insert and take.
// ----------------------------------------------------------------------------
// The set lives in a row of CAPACITY cells, slot 0 holding the smallest
// address and slots below the occupancy count holding valid entries. Every
// cell compares its entry to the request address in the same cycle; the
// row of "below" flags marks the insertion point or the matched slot, and
// each cell loads from its left or right neighbor to open or close a gap.
// A request word is taken and its result word appears in the result register
// in the following cycle: one word per cycle sustained while results are
// drained, as the whole row compares and shifts at once. A new request is
// accepted while the result register is empty or being drained in the same
// cycle. Insert of an address already present reports a duplicate, insert
// into a full row reports full and drops the address (duplicate wins), and
// a take on an empty row reports empty with a zero address. A take with
// use_preferred set removes the given address when present, otherwise the
// smallest one. No clearing pass: slots are only read below the count.
// ----------------------------------------------------------------------------
module sorted_unique_address_set #(
  parameter int CAPACITY = sus_pkg::DEFAULT_CAPACITY
) (
  input  logic      clk,
  input  logic      rst,
  sus_req_if.sink   req,
  sus_rsp_if.source rsp
);
  import sus_pkg::*;

  localparam int OCC_W = $clog2(CAPACITY + 1);

  // occupancy count (number of valid slots)
  logic [OCC_W-1:0] occupancy;
  logic [OCC_W-1:0] occupancy_next;

  // cell row wiring
  addr_t       cell_entry [CAPACITY];
  cell_flags_t cell_flags [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] eq_vec;

  op_t  op;
  logic accept;
  logic hit;
  logic is_empty;
  logic is_full;

  // result register
  logic    rsp_valid;
  addr_t   taken_address;
  status_t status;
  logic    nonempty;
  addr_t   taken_next;
  status_t status_next;
  addr_t   hit_entry;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign is_empty = (occupancy == '0);
  assign is_full  = (occupancy == OCC_W'(CAPACITY));

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_valid[i] = (occupancy > OCC_W'(i));
      eq_vec[i]     = cell_flags[i].eq;
    end
  end

  assign hit = |eq_vec;

  // entry that matched the address; one-hot because entries are unique
  always_comb begin
    hit_entry = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (eq_vec[i]) begin
        hit_entry = hit_entry | cell_entry[i];
      end
    end
  end

  // decode the request into a row operation, a status and a count change
  always_comb begin
    op             = OP_HOLD;
    status_next    = ST_OK;
    taken_next     = '0;
    occupancy_next = occupancy;
    if (accept) begin
      if (req.cmd == CMD_INSERT) begin
        if (hit) begin
          status_next = ST_DUP;
        end else if (is_full) begin
          status_next = ST_FULL;
        end else begin
          op             = OP_INSERT;
          occupancy_next = occupancy + OCC_W'(1);
        end
      end else begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else if (req.use_preferred && hit) begin
          op             = OP_TAKE_HIT;
          taken_next     = hit_entry;
          occupancy_next = occupancy - OCC_W'(1);
        end else begin
          op             = OP_TAKE_MIN;
          taken_next     = cell_entry[0];
          occupancy_next = occupancy - OCC_W'(1);
        end
      end
    end
  end

  // the row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic  prev_lt;
    addr_t prev_entry;
    addr_t next_entry;

    if (i == 0) begin : g_head
      assign prev_lt    = 1'b1;
      assign prev_entry = cell_entry[0];
    end else begin : g_body
      assign prev_lt    = cell_flags[i-1].lt;
      assign prev_entry = cell_entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_entry = cell_entry[i];
    end else begin : g_link
      assign next_entry = cell_entry[i+1];
    end

    sus_cell u_cell (
      .clk        (clk),
      .valid      (cell_valid[i]),
      .op         (op),
      .address    (req.address),
      .prev_lt    (prev_lt),
      .prev_entry (prev_entry),
      .next_entry (next_entry),
      .entry      (cell_entry[i]),
      .flags      (cell_flags[i])
    );
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      rsp_valid <= 1'b0;
    end else begin
      occupancy <= occupancy_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      taken_address <= taken_next;
      status        <= status_next;
      nonempty      <= (occupancy_next != '0);
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.taken_address = taken_address;
  assign rsp.status        = status;
  assign rsp.nonempty      = nonempty;

endmodule

@@ src/sus_cell.sv @@
// ----------------------------------------------------------------------------
// sus_cell
// One slot of the sorted row: compares against the broadcast address and
// shifts toward either neighbor.
// ----------------------------------------------------------------------------
module sus_cell (
  input  logic                clk,
  input  logic                valid,
  input  sus_pkg::op_t        op,
  input  sus_pkg::addr_t      address,
  input  logic                prev_lt,     // left neighbor's lt (1 at the head)
  input  sus_pkg::addr_t      prev_entry,  // left neighbor's entry
  input  sus_pkg::addr_t      next_entry,  // right neighbor's entry
  output sus_pkg::addr_t      entry,
  output sus_pkg::cell_flags_t flags
);
  import sus_pkg::*;

  addr_t entry_next;

  assign flags.lt = valid && (entry < address);
  assign flags.eq = valid && (entry == address);

  always_comb begin
    entry_next = entry;
    case (op)
      OP_INSERT: begin
        if (!flags.lt) begin
          entry_next = prev_lt ? address : prev_entry;
        end
      end
      OP_TAKE_MIN: begin
        entry_next = next_entry;
      end
      OP_TAKE_HIT: begin
        // slots at and above the hit close the gap
        if (!flags.lt) begin
          entry_next = next_entry;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

@@ src/sus_checker.sv @@
// ----------------------------------------------------------------------------
// sus_checker
// Port-level checks for the sorted unique address set.
// ----------------------------------------------------------------------------
module sus_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input sus_pkg::addr_t    rsp_taken_address,
  input sus_pkg::status_t  rsp_status,
  input logic              rsp_nonempty
);
  import sus_pkg::*;

  // every accepted request yields a result word in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("no result after accepted request");

  // empty take returns zero and leaves the set empty
  a_empty_take: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_EMPTY |-> !rsp_nonempty && rsp_taken_address == '0)
    else $error("empty take with address or nonempty set");

  // duplicate and full both mean something is stored, and nothing is taken
  a_dup_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_DUP || rsp_status == ST_FULL)
      |-> rsp_nonempty && rsp_taken_address == '0)
    else $error("rejected insert reports empty set or taken address");

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_taken_address)
      && $stable(rsp_status) && $stable(rsp_nonempty))
    else $error("result word changed while stalled");

endmodule

bind sorted_unique_address_set sus_checker u_sus_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_taken_address (rsp.taken_address),
  .rsp_status        (rsp.status),
  .rsp_nonempty      (rsp.nonempty)
);
